@@ hdl/positional_list_engine_unit_assert.svh @@
// Assertion macros for the positional list engine.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define PLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ple_pkg.sv @@
// Shared constants and codes for the positional list engine.
// No dependencies; used by the RAM and the top level.
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

endpackage

@@ hdl/positional_list_engine_unit.sv @@
// Top level of the positional list engine: command sequencer around one RAM.
// Depends on ple_pkg, ple_ram and positional_list_engine_unit_assert.svh.
//
// Usage: drive in_cmd, in_position and in_item_value with start high; the
// command is taken at a rising edge where start is high and busy is low.
// Every command gives exactly one result, shown for one cycle with out_valid
// high. The receiver cannot hold results off; it must take each transfer.
// The list lives in one RAM of CAPACITY words (one read, one write a cycle,
// registered read). Insert and delete move the tail one entry a cycle
// through that RAM; search scans one entry a cycle from the head.
// A full insert, an out-of-range delete or get, a search of an empty list
// and a delete of the last entry are answered from idle; busy stays low.
// Other commands go through S_RUN, which issues the reads, then S_DRAIN,
// which uses the last read data; an insert then writes its value in S_FIN.
// An insert at the end goes straight to S_FIN; a search hit ends the scan.
// Reset (rst_n low, synchronous) empties the list; stored words are not
// cleared since no entry at or above the count is ever read.
`include "positional_list_engine_unit_assert.svh"

module positional_list_engine_unit #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  input  logic signed [ple_pkg::DATA_W-1:0]   in_item_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [ple_pkg::DATA_W-1:0]   out_read_value,
  output logic [ple_pkg::POS_W-1:0]           out_found_position,
  output logic [ple_pkg::POS_W-1:0]           out_entry_count
);
  import ple_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  cmd_t                      cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             lim_r, lim_nxt;
  logic [AW-1:0]             rd_idx_r;
  logic                      rd_vld_r;
  logic [CW-1:0]             count_r, count_nxt;

  logic                      ov_r, ov_nxt;
  status_t                   ost_r, ost_nxt;
  logic signed [DATA_W-1:0]  ord_r, ord_nxt;
  logic [POS_W-1:0]          ofp_r, ofp_nxt;
  logic [POS_W-1:0]          oec_r;

  logic                      ram_wr_en;
  logic [AW-1:0]             ram_wr_addr;
  logic [DATA_W-1:0]         ram_wr_data;
  logic                      ram_rd_en;
  logic [AW-1:0]             ram_rd_addr;
  logic [DATA_W-1:0]         ram_rd_data;

  logic                      accept;
  logic                      proc;
  logic                      hit;
  logic [CMP_W-1:0]          pos_ext, cnt_ext, ins_p, hit_pos, fin_pos, cnt_nxt_ext;
  logic                      pos_ok, full;

  ple_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // decode the incoming position against the current count
  always_comb begin
    pos_ext = CMP_W'(in_position);
    cnt_ext = CMP_W'(count_r);
    pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    full    = (cnt_ext >= CMP_W'(CAPACITY));
    if (pos_ext == '0) begin
      ins_p = CMP_W'(1);
    end else if (pos_ext > cnt_ext) begin
      ins_p = cnt_ext + CMP_W'(1);
    end else begin
      ins_p = pos_ext;
    end
    hit_pos = CMP_W'(rd_idx_r) + CMP_W'(1);
    fin_pos = CMP_W'(lim_r) + CMP_W'(1);
  end

  // read data from last cycle is live in the scan and drain states
  assign proc = rd_vld_r && ((state_r == S_RUN) || (state_r == S_DRAIN));
  assign hit  = proc && (cmd_r == CMD_SEARCH) && (ram_rd_data == $unsigned(val_r));

  // sequence the command: issue reads, write back shifted words, respond
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    count_nxt   = count_r;
    ov_nxt      = 1'b0;
    ost_nxt     = ST_OK;
    ord_nxt     = '0;
    ofp_nxt     = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = rd_idx_r;
    ram_wr_data = ram_rd_data;

    // move each word read last cycle one slot up or down
    if (proc && (cmd_r == CMD_INSERT)) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = rd_idx_r + AW'(1);
    end else if (proc && (cmd_r == CMD_DELETE)) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = rd_idx_r - AW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_cmd);
          val_nxt = in_item_value;
          case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (full) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_FULL;
              end else begin
                lim_nxt = AW'(ins_p - CMP_W'(1));
                if (ins_p <= cnt_ext) begin
                  idx_nxt   = AW'(cnt_ext - CMP_W'(1));
                  state_nxt = S_RUN;
                end else begin
                  state_nxt = S_FIN;
                end
              end
            end
            CMD_DELETE: begin
              if (!pos_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_MISSING;
              end else if (pos_ext == cnt_ext) begin
                count_nxt = count_r - CW'(1);
                ov_nxt    = 1'b1;
              end else begin
                idx_nxt   = AW'(pos_ext);
                lim_nxt   = AW'(cnt_ext - CMP_W'(1));
                state_nxt = S_RUN;
              end
            end
            CMD_GET: begin
              if (!pos_ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_MISSING;
              end else begin
                idx_nxt   = AW'(pos_ext - CMP_W'(1));
                lim_nxt   = AW'(pos_ext - CMP_W'(1));
                state_nxt = S_RUN;
              end
            end
            CMD_SEARCH: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_MISSING;
              end else begin
                idx_nxt   = '0;
                lim_nxt   = AW'(cnt_ext - CMP_W'(1));
                state_nxt = S_RUN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RUN: begin
        ram_rd_en = 1'b1;
        if (hit) begin
          // stop the scan at the first match
          ov_nxt    = 1'b1;
          ofp_nxt   = hit_pos[POS_W-1:0];
          state_nxt = S_IDLE;
        end else if (idx_r == lim_r) begin
          state_nxt = S_DRAIN;
        end else if (cmd_r == CMD_INSERT) begin
          idx_nxt = idx_r - AW'(1);
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_DRAIN: begin
        case (cmd_r)
          CMD_INSERT: begin
            state_nxt = S_FIN;
          end
          CMD_DELETE: begin
            count_nxt = count_r - CW'(1);
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
          CMD_GET: begin
            ov_nxt    = 1'b1;
            ord_nxt   = $signed(ram_rd_data);
            state_nxt = S_IDLE;
          end
          default: begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
            if (hit) begin
              ofp_nxt = hit_pos[POS_W-1:0];
            end else begin
              ost_nxt = ST_MISSING;
            end
          end
        endcase
      end

      S_FIN: begin
        // drop the new value into the opened slot
        ram_wr_en   = 1'b1;
        ram_wr_addr = lim_r;
        ram_wr_data = $unsigned(val_r);
        count_nxt   = count_r + CW'(1);
        ov_nxt      = 1'b1;
        ofp_nxt     = fin_pos[POS_W-1:0];
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cnt_nxt_ext = CMP_W'(count_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= ram_rd_en;
      ov_r     <= ov_nxt;
    end
  end

  // command context and result payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    lim_r    <= lim_nxt;
    rd_idx_r <= ram_rd_addr;
    ost_r    <= ost_nxt;
    ord_r    <= ord_nxt;
    ofp_r    <= ofp_nxt;
    oec_r    <= cnt_nxt_ext[POS_W-1:0];
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_read_value     = ord_r;
  assign out_found_position = ofp_r;
  assign out_entry_count    = oec_r;

  // checks
  `PLE_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "list count above capacity")
  `PLE_ASSERT_NEXT(a_accept_progress, accept, out_valid || busy, "accepted command dropped")
  `PLE_ASSERT_IMPL(a_result_idle, out_valid, !busy, "result shown while sequencer busy")
  `PLE_ASSERT_IMPL(a_write_busy, ram_wr_en, busy, "RAM written while idle")

endmodule

@@ hdl/ple_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Defaults come from ple_pkg.
module ple_ram #(
  parameter int DATA_W = ple_pkg::DATA_W,
  parameter int DEPTH  = ple_pkg::CAPACITY_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  import ple_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
